### src/nnis_pkg.sv
package nnis_pkg;

  // field widths fixed by the pixel format and coordinate range
  localparam int unsigned COORD_W = 11;
  localparam int unsigned SIDE_W  = 12;
  localparam int unsigned STEP_W  = 28;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 4 * CHAN_W;
  localparam int unsigned CFG_W   = 28;
  localparam int unsigned CFG_IDX_W = 2;

  // coordinate times step, then the integer part of it
  localparam int unsigned PROD_W  = COORD_W + STEP_W;
  localparam int unsigned SCALE_W = PROD_W - FRAC_W;
  // row times side plus column
  localparam int unsigned LIN_W   = COORD_W + SIDE_W;

  // defaults for the top level parameters
  localparam int unsigned STORE_PIXELS_DEF = 65536;
  localparam int unsigned MAX_SIDE_DEF     = 2048;

  // configuration reset values
  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'(1);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(65536);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_COLUMN_STEP   = 2'd2,
    REG_ROW_STEP      = 2'd3
  } cfg_reg_t;

  // item actions
  typedef enum logic {
    ACT_STORE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] source_column;
    logic [COORD_W-1:0] source_row;
    logic [CHAN_W-1:0]  in_red;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_blue;
    logic [CHAN_W-1:0]  in_alpha;
    logic [COORD_W-1:0] dest_column;
    logic [COORD_W-1:0] dest_row;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              out_of_range;
  } out_item_t;

endpackage

### src/nearest_neighbor_image_scaler.sv
// Nearest-neighbor RGBA scaler over an on-chip source pixel store.
// Input channel: a word is taken at each rising edge with start high and
// busy low. busy stays low: the pipeline takes one word every clock.
// A store word writes one source pixel at row * width + column; a read
// word names a destination column and row, which are scaled by the 12.16
// steps, clamped to the source size and looked up in the store.
// Result channel: each read word gives one result word; done is high for
// exactly one cycle once the word has passed the scale multiply, clamp,
// address and range check, memory read and output register stages. Store
// words give no result. Words leave in accept order.
// Sustained rate is one word per clock, set by the single-port pixel
// memory that serves one write or one read each cycle.
// Configuration: cfg_write with cfg_index and cfg_data sets a register at
// once; write only when no word is in flight.
// Reset (rst, synchronous) clears the pipeline and sets width and height to
// 1 and both steps to 1.0. The pixel store is not cleared: read only pixels
// that were written. The receiver cannot stall; results must be taken.
module nearest_neighbor_image_scaler
  import nnis_pkg::*;
#(
  parameter int unsigned STORE_PIXELS = STORE_PIXELS_DEF,
  parameter int unsigned MAX_SIDE     = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item,
  output logic                 done,
  output out_item_t            result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned ADDR_W = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
  localparam logic [LIN_W-1:0]  STORE_LIMIT = LIN_W'(STORE_PIXELS);
  localparam logic [SIDE_W-1:0] SIDE_LIMIT  = SIDE_W'(MAX_SIDE);

  // configuration registers
  logic [SIDE_W-1:0] source_width;
  logic [SIDE_W-1:0] source_height;
  logic [STEP_W-1:0] column_step;
  logic [STEP_W-1:0] row_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIDE_RST;
      source_height <= SIDE_RST;
      column_step   <= STEP_RST;
      row_step      <= STEP_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SIDE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SIDE_W-1:0];
        REG_COLUMN_STEP:   column_step   <= cfg_data[STEP_W-1:0];
        REG_ROW_STEP:      row_step      <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes bounded to 1..MAX_SIDE
  logic [SIDE_W-1:0] eff_width;
  logic [SIDE_W-1:0] eff_height;

  always_comb begin
    if (source_width == '0) begin
      eff_width = SIDE_W'(1);
    end else if (source_width > SIDE_LIMIT) begin
      eff_width = SIDE_LIMIT;
    end else begin
      eff_width = source_width;
    end
    if (source_height == '0) begin
      eff_height = SIDE_W'(1);
    end else if (source_height > SIDE_LIMIT) begin
      eff_height = SIDE_LIMIT;
    end else begin
      eff_height = source_height;
    end
  end

  assign busy = 1'b0;

  // stage 1: register the accepted word
  logic     s1_valid;
  in_item_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1_item <= item;
  end

  // stage 2: scale destination coordinates by the steps
  logic               s2_valid;
  logic               s2_read;
  logic [PROD_W-1:0]  s2_prod_x;
  logic [PROD_W-1:0]  s2_prod_y;
  logic [COORD_W-1:0] s2_col;
  logic [COORD_W-1:0] s2_row;
  logic [PIXEL_W-1:0] s2_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_read   <= (s1_item.action == ACT_READ);
    s2_prod_x <= PROD_W'(s1_item.dest_column) * PROD_W'(column_step);
    s2_prod_y <= PROD_W'(s1_item.dest_row) * PROD_W'(row_step);
    s2_col    <= s1_item.source_column;
    s2_row    <= s1_item.source_row;
    s2_pixel  <= {s1_item.in_alpha, s1_item.in_blue, s1_item.in_green, s1_item.in_red};
  end

  // stage 3: drop the fraction and clamp; store words keep their own place
  logic [SCALE_W-1:0] scaled_x;
  logic [SCALE_W-1:0] scaled_y;
  logic [COORD_W-1:0] clamp_x;
  logic [COORD_W-1:0] clamp_y;

  always_comb begin
    scaled_x = s2_prod_x[PROD_W-1:FRAC_W];
    scaled_y = s2_prod_y[PROD_W-1:FRAC_W];
    if (scaled_x >= SCALE_W'(eff_width)) begin
      clamp_x = COORD_W'(eff_width - SIDE_W'(1));
    end else begin
      clamp_x = scaled_x[COORD_W-1:0];
    end
    if (scaled_y >= SCALE_W'(eff_height)) begin
      clamp_y = COORD_W'(eff_height - SIDE_W'(1));
    end else begin
      clamp_y = scaled_y[COORD_W-1:0];
    end
  end

  logic               s3_valid;
  logic               s3_read;
  logic [COORD_W-1:0] s3_x;
  logic [COORD_W-1:0] s3_y;
  logic [PIXEL_W-1:0] s3_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_read  <= s2_read;
    s3_x     <= s2_read ? clamp_x : s2_col;
    s3_y     <= s2_read ? clamp_y : s2_row;
    s3_pixel <= s2_pixel;
  end

  // stage 4: linear address and range check
  logic [LIN_W-1:0] lin_addr;

  assign lin_addr = LIN_W'(s3_y) * LIN_W'(eff_width) + LIN_W'(s3_x);

  logic               s4_valid;
  logic               s4_read;
  logic               s4_oor;
  logic [ADDR_W-1:0]  s4_addr;
  logic [PIXEL_W-1:0] s4_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_read  <= s3_read;
    s4_oor   <= (lin_addr >= STORE_LIMIT);
    s4_addr  <= lin_addr[ADDR_W-1:0];
    s4_pixel <= s3_pixel;
  end

  // pixel store: one write or one read a cycle, registered read data
  logic [PIXEL_W-1:0] mem [STORE_PIXELS];
  logic [PIXEL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (s4_valid && !s4_read && !s4_oor) begin
      mem[s4_addr] <= s4_pixel;
    end
    rd_data <= mem[s4_addr];
  end

  logic s5_valid;
  logic s5_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid & s4_read;
    end
    s5_oor <= s4_oor;
  end

  // output register; out of range reads give zeros with the flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
    if (s5_oor) begin
      result <= '{out_red: '0, out_green: '0, out_blue: '0, out_alpha: '0,
                  out_of_range: 1'b1};
    end else begin
      result <= '{out_red:   rd_data[CHAN_W-1:0],
                  out_green: rd_data[2*CHAN_W-1:CHAN_W],
                  out_blue:  rd_data[3*CHAN_W-1:2*CHAN_W],
                  out_alpha: rd_data[4*CHAN_W-1:3*CHAN_W],
                  out_of_range: 1'b0};
    end
  end

endmodule
